// ----- sv/ipv4c_pkg.sv -----
package ipv4c_pkg;

  typedef enum logic [3:0] {
    V_ICMP          = 4'd0,
    V_TCP           = 4'd1,
    V_UDP           = 4'd2,
    V_PROTO_UNREACH = 4'd3,
    V_NOT_LOCAL     = 4'd4,
    V_RUNT          = 4'd5,
    V_BAD_VER_IHL   = 4'd6,
    V_TRUNCATED     = 4'd7,
    V_HINT_BAD      = 4'd8,
    V_CSUM_FAIL     = 4'd9,
    V_LEN_EXCEEDS   = 4'd10
  } verdict_e;

  localparam logic [31:0] LoopbackAddr  = 32'h7F00_0001;
  localparam logic [31:0] BroadcastAddr = 32'hFFFF_FFFF;
  localparam logic [15:0] MinHeader     = 16'd20;
  localparam logic [15:0] CountMax      = 16'hFFFF;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       hint_good;
    logic       hint_bad;
  } byte_item_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [5:0]  header_length;
    logic [15:0] payload_length;
  } result_t;

endpackage

// ----- sv/ipv4c_in_stage.sv -----
module ipv4c_in_stage import ipv4c_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  byte_item_t in_item_i,
  input  logic       fire_i,
  output logic       in_stall_o,
  output logic       valid_o,
  output byte_item_t item_o
);

  logic       valid_q, valid_d;
  byte_item_t item_q;
  logic       accept;

  assign in_stall_o = valid_q && !fire_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (fire_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- sv/ipv4c_frame_track.sv -----
module ipv4c_frame_track import ipv4c_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  byte_item_t  item_i,
  input  logic [31:0] local_address_i,
  output result_t     result_o
);

  typedef struct packed {
    logic [15:0] byte_count;
    logic [5:0]  header_bytes;
    logic [3:0]  version_seen;
    logic [16:0] running_sum;
    logic [15:0] stored_checksum;
    logic [15:0] total_length;
    logic [7:0]  protocol_seen;
    logic [31:0] source_seen;
    logic [31:0] dest_seen;
    logic [1:0]  hint_flags;
    logic [7:0]  odd_byte_hold;
  } frame_t;

  frame_t st_q, st_d;
  frame_t base, upd;

  always_comb begin
    logic [15:0] pos;
    logic [7:0]  v;
    logic [16:0] s;
    logic [15:0] hb16;
    logic        is_local;
    verdict_e    verdict;

    if (item_i.first) begin
      base            = '0;
      base.hint_flags = {item_i.hint_bad, item_i.hint_good};
    end else begin
      base = st_q;
    end

    upd = base;
    pos = base.byte_count;

    if (pos == 16'd0) begin
      upd.version_seen = item_i.data[7:4];
      upd.header_bytes = {item_i.data[3:0], 2'b00};
    end else if (pos == 16'd2) begin
      upd.total_length[15:8] = item_i.data;
    end else if (pos == 16'd3) begin
      upd.total_length[7:0] = item_i.data;
    end else if (pos == 16'd9) begin
      upd.protocol_seen = item_i.data;
    end else if (pos == 16'd10) begin
      upd.stored_checksum[15:8] = item_i.data;
    end else if (pos == 16'd11) begin
      upd.stored_checksum[7:0] = item_i.data;
    end else if (pos inside {[16'd12:16'd15]}) begin
      upd.source_seen = {base.source_seen[23:0], item_i.data};
    end else if (pos inside {[16'd16:16'd19]}) begin
      upd.dest_seen = {base.dest_seen[23:0], item_i.data};
    end

    hb16 = {10'd0, upd.header_bytes};
    v    = (pos == 16'd10 || pos == 16'd11) ? 8'd0 : item_i.data;
    s    = base.running_sum + {1'b0, base.odd_byte_hold, v};
    if (pos < hb16) begin
      if (!pos[0]) begin
        upd.odd_byte_hold = v;
      end else begin
        upd.running_sum = {1'b0, s[15:0]} + {16'd0, s[16]};
      end
    end

    if (base.byte_count < CountMax) begin
      upd.byte_count = base.byte_count + 16'd1;
    end

    is_local = (upd.dest_seen == LoopbackAddr) || (upd.dest_seen == BroadcastAddr) ||
               ((local_address_i != 32'd0) && (upd.dest_seen == local_address_i));

    if (upd.byte_count < MinHeader) begin
      verdict = V_RUNT;
    end else if (upd.version_seen != 4'd4 || hb16 < MinHeader) begin
      verdict = V_BAD_VER_IHL;
    end else if (upd.byte_count < hb16) begin
      verdict = V_TRUNCATED;
    end else if (upd.hint_flags[1]) begin
      verdict = V_HINT_BAD;
    end else if (!upd.hint_flags[0] && (~upd.running_sum[15:0] != upd.stored_checksum)) begin
      verdict = V_CSUM_FAIL;
    end else if (upd.total_length > upd.byte_count) begin
      verdict = V_LEN_EXCEEDS;
    end else if (!is_local) begin
      verdict = V_NOT_LOCAL;
    end else begin
      case (upd.protocol_seen)
        ProtoIcmp: verdict = V_ICMP;
        ProtoTcp:  verdict = V_TCP;
        ProtoUdp:  verdict = V_UDP;
        default:   verdict = V_PROTO_UNREACH;
      endcase
    end

    result_o.verdict         = verdict;
    result_o.protocol_number = upd.protocol_seen;
    result_o.source_address  = upd.source_seen;
    result_o.dest_address    = upd.dest_seen;
    result_o.header_length   = upd.header_bytes;
    result_o.payload_length  = (upd.total_length > hb16) ? (upd.total_length - hb16) : 16'd0;

    st_d = item_i.last ? '0 : upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

endmodule

// ----- sv/ipv4_rx_header_classifier.sv -----
// IPv4 receive header classifier.
// The input channel carries one frame byte per transfer with first and last
// marks; the checksum hints are sampled with the first byte. The output
// channel carries one verdict with the captured header fields for each frame,
// produced by the transfer of its last byte. Both channels use valid and
// stall; a transfer happens at a clock edge with valid high and stall low.
// The local address register is written whenever cfg_we_i is high.
// A byte is held in an input register, then one pass of logic updates the
// frame state and, on a last byte, loads the result register. A verdict is
// offered from the clock edge at which its last byte leaves the input
// register. One byte is taken in every cycle unless a last byte waits
// behind a blocked verdict; the rate is set by the one-pass state update.
// While the receiver stalls, a finished verdict waits in the result register
// and bytes that do not end a frame keep flowing; only a second last byte
// waits in the input register, which then stalls the sender.
// Reset clears the frame state, the local address and both valid flags.
module ipv4_rx_header_classifier import ipv4c_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic        hint_checksum_good_i,
  input  logic        hint_checksum_bad_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  verdict_o,
  output logic [7:0]  protocol_number_o,
  output logic [31:0] source_address_o,
  output logic [31:0] dest_address_o,
  output logic [5:0]  header_length_o,
  output logic [15:0] payload_length_o
);

  logic [31:0] local_address_q;
  byte_item_t  in_item, a_item;
  logic        a_valid, fire, out_free;
  result_t     result, result_q;
  logic        out_valid_q, out_valid_d;

  assign in_item = '{data: data_byte_i, first: first_byte_i, last: last_byte_i,
                     hint_good: hint_checksum_good_i, hint_bad: hint_checksum_bad_i};

  assign out_free = !out_valid_q || !out_stall_i;
  assign fire     = a_valid && (!a_item.last || out_free);

  ipv4c_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item),
    .fire_i     (fire),
    .in_stall_o (in_stall_o),
    .valid_o    (a_valid),
    .item_o     (a_item)
  );

  ipv4c_frame_track u_frame_track (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .item_i          (a_item),
    .local_address_i (local_address_q),
    .result_o        (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_address_q <= '0;
    end else if (cfg_we_i) begin
      local_address_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (fire && a_item.last) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && a_item.last) begin
      result_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign verdict_o         = result_q.verdict;
  assign protocol_number_o = result_q.protocol_number;
  assign source_address_o  = result_q.source_address;
  assign dest_address_o    = result_q.dest_address;
  assign header_length_o   = result_q.header_length;
  assign payload_length_o  = result_q.payload_length;

`ifndef ASSERT_OFF
  a_stall_only_on_blocked_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)
  ) else $error("input stalled without a blocked result");

  a_delivered_has_header: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (verdict_o == V_ICMP || verdict_o == V_TCP || verdict_o == V_UDP ||
     verdict_o == V_PROTO_UNREACH || verdict_o == V_NOT_LOCAL)) |-> (header_length_o >= 6'd20)
  ) else $error("frame passed header checks with a short header");

  a_icmp_protocol: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && verdict_o == V_ICMP) |-> (protocol_number_o == ProtoIcmp)
  ) else $error("icmp verdict with another protocol");

  a_not_local_addr: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && verdict_o == V_NOT_LOCAL) |->
      (dest_address_o != LoopbackAddr && dest_address_o != BroadcastAddr)
  ) else $error("loopback or broadcast reported as not local");
`endif

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ipv4c_pkg::*;

  localparam int QuietLimit = 3000;
  localparam int HoldCycles = 300;
  localparam int ByteTarget = 500;
  localparam logic [31:0] DirectedLocal = 32'hC0A8_0A0A;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        first_byte_i;
  logic        last_byte_i;
  logic        hint_checksum_good_i;
  logic        hint_checksum_bad_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  verdict_o;
  logic [7:0]  protocol_number_o;
  logic [31:0] source_address_o;
  logic [31:0] dest_address_o;
  logic [5:0]  header_length_o;
  logic [15:0] payload_length_o;

  ipv4_rx_header_classifier dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .data_byte_i          (data_byte_i),
    .first_byte_i         (first_byte_i),
    .last_byte_i          (last_byte_i),
    .hint_checksum_good_i (hint_checksum_good_i),
    .hint_checksum_bad_i  (hint_checksum_bad_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .verdict_o            (verdict_o),
    .protocol_number_o    (protocol_number_o),
    .source_address_o     (source_address_o),
    .dest_address_o       (dest_address_o),
    .header_length_o      (header_length_o),
    .payload_length_o     (payload_length_o)
  );

  class verdict_board;
    logic [31:0] local_addr;
    logic [15:0] byte_cnt;
    logic [5:0]  hdr_len;
    logic [3:0]  ver;
    logic [16:0] sum_acc;
    logic [15:0] csum_field;
    logic [15:0] tot_len;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [1:0]  hints;
    logic [7:0]  hi_byte;
    result_t     expected_verdicts[$];
    int          mismatches;
    int          bytes_taken;
    int          verdicts_checked;
    int          kind_count[11];

    function new();
      local_addr = '0;
      mismatches = 0;
      bytes_taken = 0;
      verdicts_checked = 0;
      foreach (kind_count[k]) kind_count[k] = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_cnt = '0;
      hdr_len = '0;
      ver = '0;
      sum_acc = '0;
      csum_field = '0;
      tot_len = '0;
      proto = '0;
      src_addr = '0;
      dst_addr = '0;
      hints = '0;
      hi_byte = '0;
    endfunction

    function bit addr_is_local(logic [31:0] a);
      return a == LoopbackAddr || a == BroadcastAddr || (local_addr != '0 && a == local_addr);
    endfunction

    function verdict_e judge();
      logic [15:0] want_csum;
      want_csum = ~sum_acc[15:0];
      if (byte_cnt < MinHeader) return V_RUNT;
      if (ver != 4'd4 || 16'(hdr_len) < MinHeader) return V_BAD_VER_IHL;
      if (byte_cnt < 16'(hdr_len)) return V_TRUNCATED;
      if (hints[1]) return V_HINT_BAD;
      if (!hints[0] && want_csum != csum_field) return V_CSUM_FAIL;
      if (tot_len > byte_cnt) return V_LEN_EXCEEDS;
      if (!addr_is_local(dst_addr)) return V_NOT_LOCAL;
      case (proto)
        ProtoIcmp: return V_ICMP;
        ProtoTcp:  return V_TCP;
        ProtoUdp:  return V_UDP;
        default:   return V_PROTO_UNREACH;
      endcase
    endfunction

    function void note_byte(logic [7:0] d, logic f, logic l, logic g, logic b);
      int      pos;
      int      s;
      logic [7:0] v;
      result_t r;
      bytes_taken++;
      if (f) begin
        clear_frame();
        hints = {b, g};
      end
      pos = int'(byte_cnt);
      case (pos)
        0: begin
          ver = d[7:4];
          hdr_len = {d[3:0], 2'b00};
        end
        2: tot_len[15:8] = d;
        3: tot_len[7:0] = d;
        9: proto = d;
        10: csum_field[15:8] = d;
        11: csum_field[7:0] = d;
        12, 13, 14, 15: src_addr = {src_addr[23:0], d};
        16, 17, 18, 19: dst_addr = {dst_addr[23:0], d};
        default: ;
      endcase
      if (pos < int'(hdr_len)) begin
        v = (pos == 10 || pos == 11) ? 8'd0 : d;
        if (pos % 2 == 0) begin
          hi_byte = v;
        end else begin
          s = int'(sum_acc) + int'({hi_byte, v});
          sum_acc = 17'((s & 32'hFFFF) + (s >> 16));
        end
      end
      if (byte_cnt != CountMax) byte_cnt++;
      if (l) begin
        r.verdict = judge();
        r.protocol_number = proto;
        r.source_address = src_addr;
        r.dest_address = dst_addr;
        r.header_length = hdr_len;
        r.payload_length = (tot_len > 16'(hdr_len)) ? tot_len - 16'(hdr_len) : 16'd0;
        expected_verdicts.push_back(r);
        clear_frame();
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t: %s mismatch at verdict %0d: got 0x%0h, expected 0x%0h",
               $time, what, verdicts_checked, got, want);
    endtask

    task check_verdict(result_t got);
      result_t want;
      if (expected_verdicts.size() == 0) begin
        report("unexpected transfer", 32'(got.verdict), 32'd0);
        return;
      end
      want = expected_verdicts.pop_front();
      verdicts_checked++;
      kind_count[want.verdict]++;
      if (got.verdict !== want.verdict)
        report("verdict", 32'(got.verdict), 32'(want.verdict));
      if (got.protocol_number !== want.protocol_number)
        report("protocol", 32'(got.protocol_number), 32'(want.protocol_number));
      if (got.source_address !== want.source_address)
        report("source address", got.source_address, want.source_address);
      if (got.dest_address !== want.dest_address)
        report("dest address", got.dest_address, want.dest_address);
      if (got.header_length !== want.header_length)
        report("header length", 32'(got.header_length), 32'(want.header_length));
      if (got.payload_length !== want.payload_length)
        report("payload length", 32'(got.payload_length), 32'(want.payload_length));
    endtask
  endclass

  verdict_board board = new();
  result_t      seen_verdict;
  logic [7:0]   frame_q[$];
  logic [31:0]  cur_local = '0;
  int           burst_left = 0;
  int           max_gap = 6;
  bit           steady = 1'b0;
  bit           hold_req = 1'b0;
  int           frames_sent = 0;
  int           settings_used = 0;
  int           quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_verdict.verdict = verdict_e'(verdict_o);
      seen_verdict.protocol_number = protocol_number_o;
      seen_verdict.source_address = source_address_o;
      seen_verdict.dest_address = dest_address_o;
      seen_verdict.header_length = header_length_o;
      seen_verdict.payload_length = payload_length_o;
      board.check_verdict(seen_verdict);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Timed out after %0d cycles without a transfer.", quiet_cycles);
        $display("** ipv4_rx_header_classifier: FAILED **");
        $finish;
      end
    end
  end

  // The receiver changes its stall pattern after each segment of random length and, on
  // request, holds off for a long stretch so that the block fills up.
  initial begin
    int seg_left;
    int mode;
    int tick;
    seg_left = 0;
    mode = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (seg_left == 0) begin
        mode = $urandom_range(0, 4);
        seg_left = $urandom_range(20, 90);
      end
      seg_left--;
      tick++;
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 2) == 0);
        2: out_stall_i <= ($urandom_range(0, 2) != 0);
        3: out_stall_i <= (tick % 4 == 0);
        default: out_stall_i <= (tick % 16 >= 10);
      endcase
    end
  end

  task automatic send_byte(logic [7:0] d, logic f, logic l, logic g, logic b);
    int gap;
    @(negedge clk_i);
    if (!steady && burst_left <= 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, max_gap);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    data_byte_i <= d;
    first_byte_i <= f;
    last_byte_i <= l;
    hint_checksum_good_i <= g;
    hint_checksum_bad_i <= b;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_byte(d, f, l, g, b);
  endtask

  task automatic send_frame(logic g, logic b, bit with_first, bit with_last);
    for (int i = 0; i < frame_q.size(); i++) begin
      send_byte(frame_q[i], (i == 0) && with_first, (i == frame_q.size() - 1) && with_last,
                (i == 0) ? g : 1'($urandom), (i == 0) ? b : 1'($urandom));
    end
    if (with_last) frames_sent++;
  endtask

  task automatic drain_verdicts();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (board.expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_local(logic [31:0] value);
    drain_verdicts();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.local_addr = value;
    cur_local = value;
    settings_used++;
  endtask

  function automatic void build_header(logic [3:0] ver, logic [3:0] ihl, logic [15:0] tot,
                                       logic [7:0] proto, logic [31:0] src, logic [31:0] dst,
                                       bit csum_ok);
    int hlen;
    int s;
    int acc;
    logic [15:0] cs;
    frame_q.delete();
    hlen = (ihl < 4'd5) ? 20 : int'(ihl) * 4;
    repeat (hlen) frame_q.push_back(8'($urandom));
    frame_q[0] = {ver, ihl};
    frame_q[2] = tot[15:8];
    frame_q[3] = tot[7:0];
    frame_q[9] = proto;
    frame_q[10] = 8'd0;
    frame_q[11] = 8'd0;
    for (int i = 0; i < 4; i++) begin
      frame_q[12 + i] = src[31 - 8 * i -: 8];
      frame_q[16 + i] = dst[31 - 8 * i -: 8];
    end
    acc = 0;
    for (int i = 0; i + 1 < int'(ihl) * 4; i += 2) begin
      s = acc + int'({frame_q[i], frame_q[i + 1]});
      acc = (s & 32'hFFFF) + (s >> 16);
    end
    cs = ~acc[15:0];
    if (!csum_ok) cs ^= 16'($urandom_range(1, 65535));
    frame_q[10] = cs[15:8];
    frame_q[11] = cs[7:0];
  endfunction

  function automatic void add_payload(int n);
    repeat (n) frame_q.push_back(8'($urandom));
  endfunction

  function automatic void trim_frame(int n);
    while (frame_q.size() > n) void'(frame_q.pop_back());
  endfunction

  function automatic void build_random_good();
    logic [3:0]  ihl;
    int          pay;
    logic [15:0] tot;
    logic [7:0]  proto;
    logic [31:0] dst;
    ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
    pay = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
    tot = 16'(int'(ihl) * 4 + pay);
    if ($urandom_range(0, 9) == 0) tot = 16'($urandom);
    case ($urandom_range(0, 5))
      0: proto = ProtoIcmp;
      1: proto = ProtoTcp;
      2: proto = ProtoUdp;
      3: proto = 8'h00;
      4: proto = 8'hFF;
      default: proto = 8'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0, 1: dst = cur_local;
      2: dst = LoopbackAddr;
      3: dst = BroadcastAddr;
      4: dst = 32'h0;
      default: dst = $urandom;
    endcase
    build_header(4'd4, ihl, tot, proto, $urandom, dst, $urandom_range(0, 9) != 0);
    add_payload(pay);
  endfunction

  task automatic send_good(logic [7:0] proto, logic [31:0] dst, int pay);
    build_header(4'd4, 4'd5, 16'(20 + pay), proto, $urandom, dst, 1'b1);
    add_payload(pay);
    send_frame(1'b0, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic send_random_frame();
    int         kind;
    logic       g;
    logic       b;
    logic [3:0] ver;
    logic [3:0] ihl;
    kind = $urandom_range(0, 99);
    g = 1'b0;
    b = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      g = 1'($urandom);
      b = 1'($urandom);
    end
    if (kind < 62) begin
      build_random_good();
      send_frame(g, b, 1'b1, 1'b1);
    end else if (kind < 70) begin
      build_random_good();
      trim_frame($urandom_range(1, 19));
      send_frame(g, b, 1'b1, 1'b1);
    end else if (kind < 77) begin
      if ($urandom_range(0, 1) == 0) begin
        ver = 4'($urandom_range(0, 15));
        if (ver == 4'd4) ver = 4'd5;
        ihl = 4'($urandom);
      end else begin
        ver = 4'd4;
        ihl = 4'($urandom_range(0, 4));
      end
      build_header(ver, ihl, 16'($urandom_range(20, 40)), ProtoTcp, $urandom, cur_local, 1'b1);
      add_payload($urandom_range(0, 4));
      send_frame(g, b, 1'b1, 1'b1);
    end else if (kind < 84) begin
      ihl = 4'($urandom_range(6, 15));
      build_header(4'd4, ihl, 16'(int'(ihl) * 4), ProtoUdp, $urandom, cur_local, 1'b1);
      trim_frame($urandom_range(20, int'(ihl) * 4 - 1));
      send_frame(g, b, 1'b1, 1'b1);
    end else if (kind < 90) begin
      build_random_good();
      send_frame(g, b, 1'b0, 1'b1);
    end else if (kind < 95) begin
      build_random_good();
      trim_frame($urandom_range(1, 30));
      send_frame(g, b, 1'b1, 1'b0);
      build_random_good();
      send_frame(g, b, 1'b1, 1'b1);
    end else begin
      repeat ($urandom_range(1, 6))
        send_byte(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int          mark;
    int          frames_mark;
    logic [31:0] setting;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    first_byte_i = 1'b0;
    last_byte_i = 1'b0;
    hint_checksum_good_i = 1'b0;
    hint_checksum_bad_i = 1'b0;
    out_stall_i = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    write_local(DirectedLocal);
    send_good(ProtoIcmp, DirectedLocal, 0);
    send_good(ProtoTcp, LoopbackAddr, 4);
    send_good(ProtoUdp, BroadcastAddr, 1);
    send_good(8'hFF, DirectedLocal, 0);
    send_good(ProtoTcp, 32'h0A00_0001, 2);
    send_good(ProtoUdp, 32'h0, 0);
    frame_q.delete();
    frame_q.push_back(8'h45);
    send_frame(1'b0, 1'b0, 1'b1, 1'b1);
    build_header(4'd4, 4'd5, 16'd20, ProtoTcp, $urandom, DirectedLocal, 1'b1);
    trim_frame(19);
    send_frame(1'b0, 1'b0, 1'b1, 1'b1);
    build_header(4'd6, 4'd5, 16'd20, ProtoTcp, $urandom, DirectedLocal, 1'b1);
    send_frame(1'b0, 1'b0, 1'b1, 1'b1);
    build_header(4'd4, 4'd4, 16'd20, ProtoTcp, $urandom, DirectedLocal, 1'b1);
    send_frame(1'b0, 1'b0, 1'b1, 1'b1);
    build_header(4'hF, 4'hF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_frame(1'b0, 1'b0, 1'b1, 1'b1);
    build_header(4'd4, 4'hF, 16'd60, ProtoUdp, 32'hFFFF_FFFF, BroadcastAddr, 1'b1);
    send_frame(1'b0, 1'b0, 1'b1, 1'b1);
    build_header(4'd4, 4'hF, 16'd60, ProtoUdp, 32'h0, BroadcastAddr, 1'b1);
    trim_frame(40);
    send_frame(1'b0, 1'b0, 1'b1, 1'b1);
    build_header(4'd4, 4'd5, 16'd20, ProtoIcmp, $urandom, DirectedLocal, 1'b1);
    send_frame(1'b0, 1'b1, 1'b1, 1'b1);
    build_header(4'd4, 4'd5, 16'd20, ProtoIcmp, $urandom, DirectedLocal, 1'b1);
    send_frame(1'b1, 1'b1, 1'b1, 1'b1);
    build_header(4'd4, 4'd5, 16'd20, ProtoIcmp, $urandom, DirectedLocal, 1'b0);
    send_frame(1'b0, 1'b0, 1'b1, 1'b1);
    build_header(4'd4, 4'd5, 16'd20, ProtoIcmp, $urandom, DirectedLocal, 1'b0);
    send_frame(1'b1, 1'b0, 1'b1, 1'b1);
    build_header(4'd4, 4'd5, 16'hFFFF, ProtoTcp, $urandom, DirectedLocal, 1'b1);
    send_frame(1'b0, 1'b0, 1'b1, 1'b1);
    build_header(4'd4, 4'd5, 16'd8, ProtoTcp, $urandom, DirectedLocal, 1'b1);
    send_frame(1'b0, 1'b0, 1'b1, 1'b1);
    build_header(4'd4, 4'd5, 16'd22, ProtoUdp, $urandom, DirectedLocal, 1'b1);
    add_payload(2);
    send_frame(1'b0, 1'b0, 1'b0, 1'b1);
    build_header(4'd4, 4'd5, 16'd20, ProtoTcp, $urandom, DirectedLocal, 1'b1);
    trim_frame(7);
    send_frame(1'b0, 1'b0, 1'b1, 1'b0);
    send_good(ProtoTcp, DirectedLocal, 3);

    // Let the block back up against a long receiver hold-off, then let it
    // empty out completely before going on.
    hold_req = 1'b1;
    repeat (10) begin
      frame_q.delete();
      add_payload($urandom_range(1, 3));
      send_frame(1'b0, 1'b0, 1'b1, 1'b1);
    end
    drain_verdicts();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: setting = 32'h0;
        1: setting = 32'hFFFF_FFFF;
        2: setting = 32'h0000_0001;
        default: setting = $urandom;
      endcase
      write_local(setting);
      steady = (p == 2);
      max_gap = 2 + 2 * p;
      mark = board.bytes_taken;
      frames_mark = frames_sent;
      while (board.bytes_taken - mark < ByteTarget / 20 || frames_sent - frames_mark < 2)
        send_random_frame();
    end
    steady = 1'b0;

    drain_verdicts();
    $display("Run covered %0d frames in %0d byte transfers under %0d address settings;",
             frames_sent, board.bytes_taken, settings_used);
    $display({"%0d verdicts checked: icmp %0d tcp %0d udp %0d unreach %0d not-local %0d ",
              "runt %0d ver/ihl %0d trunc %0d hint %0d csum %0d len %0d"},
             board.verdicts_checked,
             board.kind_count[V_ICMP], board.kind_count[V_TCP], board.kind_count[V_UDP],
             board.kind_count[V_PROTO_UNREACH], board.kind_count[V_NOT_LOCAL],
             board.kind_count[V_RUNT], board.kind_count[V_BAD_VER_IHL],
             board.kind_count[V_TRUNCATED], board.kind_count[V_HINT_BAD],
             board.kind_count[V_CSUM_FAIL], board.kind_count[V_LEN_EXCEEDS]);
    if (board.mismatches == 0) begin
      $display("** ipv4_rx_header_classifier: PASSED **");
    end else begin
      $display("** ipv4_rx_header_classifier: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ipv4c_pkg.sv
sv/ipv4c_in_stage.sv
sv/ipv4c_frame_track.sv
sv/ipv4_rx_header_classifier.sv
bench/tb_top.sv
